@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RLFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlfc: property violated");

// Next-cycle implication, checked at every rising edge outside reset.
`define RLFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlfc: property violated");

`endif

@@ rtl/rlfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rlfc_pkg
// Types and constants shared by the run-length frame class cursor modules.
// ----------------------------------------------------------------------------
package rlfc_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int POS_W       = $clog2(TABLE_DEPTH);
    localparam int LIVE_W      = POS_W + 1;

    // Field widths.
    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 10;
    localparam int COUNT_W   = 32;
    localparam int OFFSET_W  = 32;
    localparam int FRAME_W   = 48;
    localparam int VERDICT_W = 2;
    localparam int TOTAL_W   = 11;

    // Walk distance holds a frame delta grown by one negative entry step.
    localparam int DIST_W = FRAME_W + 1;
    // Remaining frames in an entry: count minus offset, signed.
    localparam int REM_W  = COUNT_W + 2;

    // Queue depths.
    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ENTRY_TOTAL = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE   = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_IN_ORDER  = 2'd0,
        VERDICT_REORDERED = 2'd1,
        VERDICT_UNKNOWN   = 2'd2
    } t_verdict;

    typedef struct packed {
        t_cmd                cmd;
        logic [INDEX_W-1:0]  entry_index;
        logic [COUNT_W-1:0]  entry_count;
        logic [OFFSET_W-1:0] entry_offset;
        logic [FRAME_W-1:0]  target_frame;
    } t_item;

    typedef struct packed {
        logic  vld;
        t_item item;
    } t_front_out;

    typedef struct packed {
        logic     vld;
        t_verdict verdict;
    } t_result;

endpackage

@@ rtl/run_length_frame_class_cursor.sv @@
// ----------------------------------------------------------------------------
// run_length_frame_class_cursor
// Run-length table of (count, offset) entries with a frame cursor that is
// walked one entry at a time to classify a queried frame.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake                  | Payload
//  ----------+----------------------------+------------------------------------
//  command   | push / full                | i_command, i_entry_index,
//            |                            | i_entry_count, i_entry_offset,
//            |                            | i_target_frame
//  result    | pop / empty                | o_verdict
//  config    | psel, penable, pwrite      | paddr, pwdata, prdata (entry_total)
//
//  Write, restart: executed from the idle state. Query: the step state answers
//  when the target lies in the current entry; a forward step passes the wait
//  state, a backward step wait and load; each step waits on the table read port.
//  A four-deep command queue and a two-deep result queue sit on either side.
//  Reset is synchronous; it clears the cursor, the queues and entry_total.
//  Table contents are undefined until written; no clearing pass is run.
//
module run_length_frame_class_cursor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Command channel.
    input  logic                              push,
    output logic                              full,
    input  logic [rlfc_pkg::CMD_W-1:0]        i_command,
    input  logic [rlfc_pkg::INDEX_W-1:0]      i_entry_index,
    input  logic [rlfc_pkg::COUNT_W-1:0]      i_entry_count,
    input  logic signed [rlfc_pkg::OFFSET_W-1:0] i_entry_offset,
    input  logic [rlfc_pkg::FRAME_W-1:0]      i_target_frame,
    // Result channel.
    output logic                              empty,
    input  logic                              pop,
    output logic [rlfc_pkg::VERDICT_W-1:0]    o_verdict,
    // Configuration port.
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rlfc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rlfc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rlfc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

`include "assert_macros.svh"

    logic [rlfc_pkg::TOTAL_W-1:0]  r_entry_total;
    logic [rlfc_pkg::LIVE_W-1:0]   w_live_total;
    logic                          w_reg_sel;
    rlfc_pkg::t_item               w_item;
    rlfc_pkg::t_front_out          w_front;
    logic                          w_take;
    rlfc_pkg::t_result             w_result;
    logic                          w_outq_full;
    rlfc_pkg::t_verdict            w_verdict;

    // Configuration register.
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[rlfc_pkg::APB_ADDR_W-1:2] == rlfc_pkg::REG_ENTRY_TOTAL);
    assign prdata    = w_reg_sel ? rlfc_pkg::APB_DATA_W'(r_entry_total) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_total <= '0;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_entry_total <= pwdata[rlfc_pkg::TOTAL_W-1:0];
        end
    end

    // Entries in use, limited to the table depth.
    assign w_live_total = (32'(r_entry_total) > rlfc_pkg::TABLE_DEPTH) ?
                          rlfc_pkg::LIVE_W'(rlfc_pkg::TABLE_DEPTH) :
                          rlfc_pkg::LIVE_W'(r_entry_total);

    // Command transaction payload.
    assign w_item.cmd          = rlfc_pkg::t_cmd'(i_command);
    assign w_item.entry_index  = i_entry_index;
    assign w_item.entry_count  = i_entry_count;
    assign w_item.entry_offset = i_entry_offset;
    assign w_item.target_frame = i_target_frame;

    rlfc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (w_item),
        .o_front (w_front),
        .i_take  (w_take)
    );

    rlfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_front      (w_front),
        .o_take       (w_take),
        .i_live_total (w_live_total),
        .i_out_full   (w_outq_full),
        .o_result     (w_result)
    );

    rlfc_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_result  (w_result),
        .o_full    (w_outq_full),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_verdict (w_verdict)
    );

    assign o_verdict = w_verdict;

    // A finished query always finds room in the result queue.
    `RLFC_ASSERT_IMPL(a_result_room, i_clk, i_rst_n, w_result.vld, !w_outq_full)
    // A result pushed into an empty result queue is visible in the next cycle.
    `RLFC_ASSERT_NEXT(a_result_shows, i_clk, i_rst_n, w_result.vld && empty, !empty)
    // An accepted command other than a no-op reaches the execution unit.
    `RLFC_ASSERT_NEXT(a_cmd_queued, i_clk, i_rst_n,
        push && !full && (i_command != rlfc_pkg::CMD_NOP), w_front.vld)

endmodule

@@ rtl/rlfc_front.sv @@
// ----------------------------------------------------------------------------
// rlfc_front
// Accepts command transactions, drops the unused command code and holds the
// rest in a short queue in front of the execution unit.
// ----------------------------------------------------------------------------
module rlfc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  rlfc_pkg::t_item     i_item,
    output rlfc_pkg::t_front_out o_front,
    input  logic                i_take
);

    rlfc_pkg::t_item                r_q [rlfc_pkg::FQ_DEPTH];
    logic [rlfc_pkg::FQ_PTR_W-1:0]  r_wr_ptr;
    logic [rlfc_pkg::FQ_PTR_W-1:0]  r_rd_ptr;
    logic [rlfc_pkg::FQ_PTR_W:0]    r_count;
    logic [rlfc_pkg::FQ_PTR_W:0]    n_count;
    logic                           w_wr;
    logic                           w_rd;

    // Classification: a no-op command never enters the queue.
    assign o_full = (r_count == (rlfc_pkg::FQ_PTR_W + 1)'(rlfc_pkg::FQ_DEPTH));
    assign w_wr   = i_push && !o_full && (i_item.cmd != rlfc_pkg::CMD_NOP);
    assign w_rd   = i_take && (r_count != '0);

    assign o_front.vld  = (r_count != '0);
    assign o_front.item = r_q[r_rd_ptr];

    // Occupancy update.
    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ rtl/rlfc_back.sv @@
// ----------------------------------------------------------------------------
// rlfc_back
// Executes queued commands: holds the run-length table and the cursor and
// walks the cursor one entry per step to answer a query.
// ----------------------------------------------------------------------------
module rlfc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rlfc_pkg::t_front_out        i_front,
    output logic                        o_take,
    input  logic [rlfc_pkg::LIVE_W-1:0] i_live_total,
    input  logic                        i_out_full,
    output rlfc_pkg::t_result           o_result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_WAIT,
        S_BLOAD
    } t_state;

    // Table memories and their registered read data.
    logic [rlfc_pkg::COUNT_W-1:0]  r_mem_cnt [rlfc_pkg::TABLE_DEPTH];
    logic [rlfc_pkg::OFFSET_W-1:0] r_mem_ofs [rlfc_pkg::TABLE_DEPTH];
    logic [rlfc_pkg::COUNT_W-1:0]  r_cnt_q;
    logic [rlfc_pkg::OFFSET_W-1:0] r_ofs_q;
    logic [rlfc_pkg::OFFSET_W-1:0] r_ofs0;

    // Sequencer state, cursor and walk registers.
    t_state                        r_state,  n_state;
    logic [rlfc_pkg::FRAME_W-1:0]  r_cur,    n_cur;
    logic [rlfc_pkg::POS_W-1:0]    r_pos,    n_pos;
    logic [rlfc_pkg::COUNT_W-1:0]  r_off,    n_off;
    logic [rlfc_pkg::FRAME_W-1:0]  r_tgt,    n_tgt;
    logic [rlfc_pkg::DIST_W-1:0]   r_dist,   n_dist;
    logic                          r_fwd,    n_fwd;
    logic                          r_res_vld, n_res_vld;
    rlfc_pkg::t_verdict            r_res_verdict, n_res_verdict;

    logic                          w_mem_we;
    logic [rlfc_pkg::POS_W-1:0]    w_waddr;
    logic                          w_slot_ok;
    logic signed [rlfc_pkg::REM_W-1:0] w_remain;
    logic [rlfc_pkg::DIST_W-1:0]   w_rem_dist;
    logic [rlfc_pkg::FRAME_W-1:0]  w_rem_frame;
    logic                          w_fwd_hit;
    logic                          w_last_fwd;
    logic                          w_bwd_more;
    logic                          w_off_table;
    logic                          w_ahead;
    rlfc_pkg::t_verdict            w_verdict;

    // A query waits until the result queue has room for its answer.
    assign o_take = (r_state == S_IDLE) && i_front.vld &&
                    ((i_front.item.cmd != rlfc_pkg::CMD_QUERY) ||
                     (!i_out_full && !r_res_vld));

    assign o_result.vld     = r_res_vld;
    assign o_result.verdict = r_res_verdict;

    // Write slot decode.
    assign w_slot_ok = (32'(i_front.item.entry_index) < rlfc_pkg::TABLE_DEPTH);
    assign w_waddr   = rlfc_pkg::POS_W'(i_front.item.entry_index);

    // Forward step: frames left in the current entry and the stop test.
    assign w_remain    = $signed({2'b00, r_cnt_q}) - $signed({2'b00, r_off});
    assign w_rem_dist  = {{(rlfc_pkg::DIST_W - rlfc_pkg::REM_W){w_remain[rlfc_pkg::REM_W-1]}},
                          w_remain};
    assign w_rem_frame = {{(rlfc_pkg::FRAME_W - rlfc_pkg::REM_W){w_remain[rlfc_pkg::REM_W-1]}},
                          w_remain};
    assign w_fwd_hit   = !w_remain[rlfc_pkg::REM_W-1] && (w_remain != '0) &&
                         (r_dist < w_rem_dist);
    assign w_last_fwd  = (({1'b0, r_pos} + rlfc_pkg::LIVE_W'(1)) >= i_live_total);

    // Backward step: the target lies before the start of the current entry.
    assign w_bwd_more  = (r_dist > rlfc_pkg::DIST_W'(r_off));

    // Query start tests.
    assign w_off_table = ({1'b0, r_pos} >= i_live_total);
    assign w_ahead     = (i_front.item.target_frame > r_cur);

    // Signed offset comparison against the first entry.
    assign w_verdict = ($signed(r_ofs_q) < $signed(r_ofs0)) ?
                       rlfc_pkg::VERDICT_REORDERED : rlfc_pkg::VERDICT_IN_ORDER;

    // Next-state logic of the sequencer.
    always_comb begin
        n_state       = r_state;
        n_cur         = r_cur;
        n_pos         = r_pos;
        n_off         = r_off;
        n_tgt         = r_tgt;
        n_dist        = r_dist;
        n_fwd         = r_fwd;
        n_res_vld     = 1'b0;
        n_res_verdict = r_res_verdict;
        w_mem_we      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (o_take) begin
                    case (i_front.item.cmd)
                        rlfc_pkg::CMD_WRITE: begin
                            w_mem_we = w_slot_ok;
                        end
                        rlfc_pkg::CMD_QUERY: begin
                            n_tgt = i_front.item.target_frame;
                            if (w_off_table) begin
                                n_res_vld     = 1'b1;
                                n_res_verdict = rlfc_pkg::VERDICT_UNKNOWN;
                            end else begin
                                n_fwd   = w_ahead;
                                n_dist  = w_ahead ?
                                          ({1'b0, i_front.item.target_frame} - {1'b0, r_cur}) :
                                          ({1'b0, r_cur} - {1'b0, i_front.item.target_frame});
                                n_state = S_STEP;
                            end
                        end
                        rlfc_pkg::CMD_RESTART: begin
                            n_cur = '0;
                            n_pos = '0;
                            n_off = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_STEP: begin
                if (r_fwd) begin
                    if (w_fwd_hit) begin
                        n_off         = r_off + r_dist[rlfc_pkg::COUNT_W-1:0];
                        n_cur         = r_tgt;
                        n_res_vld     = 1'b1;
                        n_res_verdict = w_verdict;
                        n_state       = S_IDLE;
                    end else if (w_last_fwd) begin
                        n_res_vld     = 1'b1;
                        n_res_verdict = rlfc_pkg::VERDICT_UNKNOWN;
                        n_state       = S_IDLE;
                    end else begin
                        n_cur   = r_cur + w_rem_frame;
                        n_dist  = r_dist - w_rem_dist;
                        n_pos   = r_pos + 1'b1;
                        n_off   = '0;
                        n_state = S_WAIT;
                    end
                end else begin
                    if (w_bwd_more) begin
                        if (r_pos == '0) begin
                            n_res_vld     = 1'b1;
                            n_res_verdict = rlfc_pkg::VERDICT_UNKNOWN;
                            n_state       = S_IDLE;
                        end else begin
                            n_cur   = r_cur - rlfc_pkg::FRAME_W'(r_off) -
                                      rlfc_pkg::FRAME_W'(1);
                            n_dist  = r_dist - rlfc_pkg::DIST_W'(r_off) -
                                      rlfc_pkg::DIST_W'(1);
                            n_pos   = r_pos - 1'b1;
                            n_state = S_WAIT;
                        end
                    end else begin
                        n_off         = r_off - r_dist[rlfc_pkg::COUNT_W-1:0];
                        n_cur         = r_tgt;
                        n_res_vld     = 1'b1;
                        n_res_verdict = w_verdict;
                        n_state       = S_IDLE;
                    end
                end
            end
            S_WAIT: begin
                // The table read for the new entry lands at the end of this cycle.
                n_state = r_fwd ? S_STEP : S_BLOAD;
            end
            S_BLOAD: begin
                // Entering an entry from its end puts the cursor on its last frame.
                n_off   = r_cnt_q - rlfc_pkg::COUNT_W'(1);
                n_state = S_STEP;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer state, cursor and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cur         <= '0;
            r_pos         <= '0;
            r_off         <= '0;
            r_tgt         <= '0;
            r_dist        <= '0;
            r_fwd         <= 1'b0;
            r_res_vld     <= 1'b0;
            r_res_verdict <= rlfc_pkg::VERDICT_IN_ORDER;
        end else begin
            r_state       <= n_state;
            r_cur         <= n_cur;
            r_pos         <= n_pos;
            r_off         <= n_off;
            r_tgt         <= n_tgt;
            r_dist        <= n_dist;
            r_fwd         <= n_fwd;
            r_res_vld     <= n_res_vld;
            r_res_verdict <= n_res_verdict;
        end
    end

    // Table memories: one write port, one registered read at the cursor entry.
    // Entry 0's offset is mirrored in a register for the comparison.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem_cnt[w_waddr] <= i_front.item.entry_count;
            r_mem_ofs[w_waddr] <= i_front.item.entry_offset;
            if (w_waddr == '0) begin
                r_ofs0 <= i_front.item.entry_offset;
            end
        end
        r_cnt_q <= r_mem_cnt[r_pos];
        r_ofs_q <= r_mem_ofs[r_pos];
    end

endmodule

@@ rtl/rlfc_outq.sv @@
// ----------------------------------------------------------------------------
// rlfc_outq
// Result queue that decouples the execution unit from the result consumer.
// ----------------------------------------------------------------------------
module rlfc_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlfc_pkg::t_result   i_result,
    output logic                o_full,
    output logic                o_empty,
    input  logic                i_pop,
    output rlfc_pkg::t_verdict  o_verdict
);

    rlfc_pkg::t_verdict             r_q [rlfc_pkg::OQ_DEPTH];
    logic [rlfc_pkg::OQ_PTR_W-1:0]  r_wr_ptr;
    logic [rlfc_pkg::OQ_PTR_W-1:0]  r_rd_ptr;
    logic [rlfc_pkg::OQ_PTR_W:0]    r_count;
    logic [rlfc_pkg::OQ_PTR_W:0]    n_count;
    logic                           w_wr;
    logic                           w_rd;

    assign o_full    = (r_count == (rlfc_pkg::OQ_PTR_W + 1)'(rlfc_pkg::OQ_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_verdict = r_q[r_rd_ptr];
    assign w_wr      = i_result.vld && !o_full;
    assign w_rd      = i_pop && !o_empty;

    // Occupancy update.
    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (!w_wr && w_rd) begin
            n_count = r_count - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wr_ptr] <= i_result.verdict;
        end
    end

endmodule

@@ tb/tb_run_length_frame_class_cursor.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_run_length_frame_class_cursor
// Self-checking bench for the run-length frame class cursor. A directed table
// covers empty and off-table cursors, walks that leave the table, backward
// steps into zero-count entries and signed offset extremes. Random episodes
// then fill up to 48 of the reachable entries, set entry_total over its range and
// issue commands, many of them queries near the cursor. Each transaction is run
// through an in-bench cursor model in sending order; every popped verdict is compared with it.
// ----------------------------------------------------------------------------
module tb_run_length_frame_class_cursor;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 40;
    localparam int RUN_LIMIT_NS  = 50_000_000;
    localparam int RANDOM_ITEMS  = 430;
    localparam int FILL_CAP      = 48;

    // One line of the directed table: either a command or an entry_total change.
    typedef struct {
        bit                           sets_total;
        logic [rlfc_pkg::TOTAL_W-1:0] total;
        rlfc_pkg::t_item              item;
        bit                           has_verdict;
        rlfc_pkg::t_verdict           verdict;
    } t_stim_row;

    logic                               i_clk   = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               push    = 1'b0;
    logic                               full;
    rlfc_pkg::t_item                    item_d  = '0;
    logic                               empty;
    logic                               pop     = 1'b0;
    logic [rlfc_pkg::VERDICT_W-1:0]     o_verdict;
    logic                               psel    = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite  = 1'b0;
    logic [rlfc_pkg::APB_ADDR_W-1:0]    paddr   = '0;
    logic [rlfc_pkg::APB_DATA_W-1:0]    pwdata  = '0;
    logic [rlfc_pkg::APB_DATA_W-1:0]    prdata;
    logic                               pready;

    // Cursor model state.
    logic [rlfc_pkg::COUNT_W-1:0]       run_counts  [rlfc_pkg::TABLE_DEPTH];
    logic [rlfc_pkg::OFFSET_W-1:0]      run_offsets [rlfc_pkg::TABLE_DEPTH];
    logic [rlfc_pkg::FRAME_W-1:0]       cur_frame_q    = '0;
    int unsigned                        cur_slot_q     = 0;
    logic [rlfc_pkg::COUNT_W-1:0]       cur_inset_q    = '0;
    logic [rlfc_pkg::TOTAL_W-1:0]       live_entries_q = '0;

    bit                                 slot_written [rlfc_pkg::TABLE_DEPTH];
    rlfc_pkg::t_verdict                 pending_verdicts [$];
    int                                 error_total  = 0;
    int                                 tx_idle_pct  = 37;
    int                                 rx_idle_pct  = 54;

    run_length_frame_class_cursor dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_command      (item_d.cmd),
        .i_entry_index  (item_d.entry_index),
        .i_entry_count  (item_d.entry_count),
        .i_entry_offset (item_d.entry_offset),
        .i_target_frame (item_d.target_frame),
        .empty          (empty),
        .pop            (pop),
        .o_verdict      (o_verdict),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Walk the cursor to the target one entry at a time and classify the frame.
    // With commit low the cursor is left alone; blind flags a never-written read.
    function automatic rlfc_pkg::t_verdict walk_to_frame(
            input logic [rlfc_pkg::FRAME_W-1:0] target, input bit commit,
            output bit blind);
        int unsigned                  live;
        int unsigned                  slot;
        logic [rlfc_pkg::COUNT_W-1:0] inset;
        longint                       cur;
        longint                       tgt;
        longint                       remain;
        logic [63:0]                  gap;
        bit                           stop;
        rlfc_pkg::t_verdict           verdict;
        live    = (live_entries_q > rlfc_pkg::TABLE_DEPTH) ? rlfc_pkg::TABLE_DEPTH
                                                           : live_entries_q;
        blind   = 1'b0;
        stop    = 1'b0;
        verdict = rlfc_pkg::VERDICT_UNKNOWN;
        if (cur_slot_q >= live)
            return rlfc_pkg::VERDICT_UNKNOWN;
        slot  = cur_slot_q;
        inset = cur_inset_q;
        cur   = longint'({16'd0, cur_frame_q});
        tgt   = longint'({16'd0, target});
        if (tgt > cur) begin
            forever begin
                blind  |= !slot_written[slot];
                remain  = longint'({32'd0, run_counts[slot]}) - longint'({32'd0, inset});
                if (tgt - cur < remain)
                    break;
                // The steps already taken stay in the cursor on a failed walk.
                if (slot + 1 >= live) begin
                    stop = 1'b1;
                    break;
                end
                cur   = cur + remain;
                slot  = slot + 1;
                inset = '0;
            end
            if (!stop) begin
                inset = inset + 32'(tgt - cur);
                cur   = tgt;
            end
        end else if (tgt < cur) begin
            gap = cur - tgt;
            while (!stop && (gap > {32'd0, inset})) begin
                if (slot == 0) begin
                    stop = 1'b1;
                end else begin
                    cur    = cur - longint'({32'd0, inset}) - 1;
                    slot   = slot - 1;
                    blind |= !slot_written[slot];
                    // A zero-count entry leaves the position at all ones.
                    inset  = run_counts[slot] - 32'd1;
                    gap    = cur - tgt;
                end
            end
            if (!stop) begin
                inset = inset - 32'(cur - tgt);
                cur   = tgt;
            end
        end
        if (!stop) begin
            blind |= !slot_written[slot] || !slot_written[0];
            if ($signed(run_offsets[slot]) < $signed(run_offsets[0]))
                verdict = rlfc_pkg::VERDICT_REORDERED;
            else
                verdict = rlfc_pkg::VERDICT_IN_ORDER;
        end
        if (commit) begin
            cur_frame_q = cur[rlfc_pkg::FRAME_W-1:0];
            cur_slot_q  = slot;
            cur_inset_q = inset;
        end
        return verdict;
    endfunction

    // Apply one transaction to the model; returns 1 when it yields a verdict.
    function automatic bit step_predictor(input rlfc_pkg::t_item it,
                                          output rlfc_pkg::t_verdict verdict);
        bit blind;
        verdict = rlfc_pkg::VERDICT_UNKNOWN;
        case (it.cmd)
            rlfc_pkg::CMD_WRITE: begin
                run_counts[it.entry_index]   = it.entry_count;
                run_offsets[it.entry_index]  = it.entry_offset;
                slot_written[it.entry_index] = 1'b1;
            end
            rlfc_pkg::CMD_QUERY: begin
                verdict = walk_to_frame(it.target_frame, 1'b1, blind);
                return 1'b1;
            end
            rlfc_pkg::CMD_RESTART: begin
                cur_frame_q = '0;
                cur_slot_q  = 0;
                cur_inset_q = '0;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic t_stim_row cmd_row(input rlfc_pkg::t_cmd c,
                                          input logic [rlfc_pkg::INDEX_W-1:0] idx,
                                          input logic [rlfc_pkg::COUNT_W-1:0] cnt,
                                          input logic [rlfc_pkg::OFFSET_W-1:0] off,
                                          input logic [rlfc_pkg::FRAME_W-1:0] tgt);
        t_stim_row r;
        r.sets_total  = 1'b0;
        r.total       = '0;
        r.item        = '{cmd: c, entry_index: idx, entry_count: cnt, entry_offset: off,
                          target_frame: tgt};
        r.has_verdict = 1'b0;
        r.verdict     = rlfc_pkg::VERDICT_IN_ORDER;
        return r;
    endfunction

    function automatic t_stim_row verdict_row(input logic [rlfc_pkg::FRAME_W-1:0] tgt,
                                              input rlfc_pkg::t_verdict v);
        t_stim_row r;
        r = cmd_row(rlfc_pkg::CMD_QUERY, '0, '0, '0, tgt);
        r.has_verdict = 1'b1;
        r.verdict     = v;
        return r;
    endfunction

    function automatic t_stim_row total_row(input logic [rlfc_pkg::TOTAL_W-1:0] n);
        t_stim_row r;
        r = cmd_row(rlfc_pkg::CMD_NOP, '0, '0, '0, '0);
        r.sets_total = 1'b1;
        r.total      = n;
        return r;
    endfunction

    // Random command; a query that would read a never-written entry is
    // turned into a restart, so only written entries are ever read.
    function automatic rlfc_pkg::t_item random_item(input int unsigned live);
        rlfc_pkg::t_item it;
        int unsigned     pick;
        bit              blind;
        it.cmd          = rlfc_pkg::CMD_QUERY;
        it.entry_index  = rlfc_pkg::INDEX_W'($urandom);
        it.entry_count  = $urandom;
        it.entry_offset = $urandom;
        it.target_frame = rlfc_pkg::FRAME_W'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 45) begin
            it.target_frame = cur_frame_q - 48'd8 + 48'($urandom_range(24));
        end else if (pick < 53) begin
            // Keep the full-range target.
        end else if (pick < 85) begin
            it.cmd = rlfc_pkg::CMD_WRITE;
            if (pick < 78 && live != 0)
                it.entry_index = rlfc_pkg::INDEX_W'($urandom_range(live - 1));
            if ($urandom_range(9) < 7)
                it.entry_count = $urandom_range(6);
        end else if (pick < 93) begin
            it.cmd = rlfc_pkg::CMD_RESTART;
        end else begin
            it.cmd = rlfc_pkg::CMD_NOP;
        end
        if (it.cmd == rlfc_pkg::CMD_QUERY) begin
            void'(walk_to_frame(it.target_frame, 1'b0, blind));
            if (blind)
                it.cmd = rlfc_pkg::CMD_RESTART;
        end
        return it;
    endfunction

    // Offer one transaction after a random gap and hold it until it is taken.
    // The model advances in sending order; a typed verdict replaces its answer.
    task automatic send_item(input rlfc_pkg::t_item it, input bit has_hint,
                             input rlfc_pkg::t_verdict hint);
        rlfc_pkg::t_verdict predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        item_d <= it;
        if (step_predictor(it, predicted))
            pending_verdicts.push_back(has_hint ? hint : predicted);
        do @(posedge i_clk); while (full);
    endtask

    // Stop sending, collect every outstanding verdict and let the block settle.
    task automatic wait_until_idle();
        push <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of entry_total: setup cycle, then access until pready.
    task automatic write_total(input logic [rlfc_pkg::TOTAL_W-1:0] n);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {rlfc_pkg::REG_ENTRY_TOTAL, 2'b00};
        pwdata  <= {{(rlfc_pkg::APB_DATA_W - rlfc_pkg::TOTAL_W){1'b0}}, n};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        live_entries_q = n;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: pop at random according to the current idle rate.
    always @(posedge i_clk)
        pop <= ($urandom_range(99) >= rx_idle_pct);

    // Check each popped verdict against the oldest expected one.
    always @(posedge i_clk) begin : monitor
        rlfc_pkg::t_verdict expected;
        if (i_rst_n && pop && !empty) begin
            if (pending_verdicts.size() == 0) begin
                error_total++;
                $error("verdict: expected none, actual %0d", o_verdict);
            end else begin
                expected = pending_verdicts.pop_front();
                if (o_verdict !== expected) begin
                    error_total++;
                    $error("verdict: expected %0d, actual %0d", expected, o_verdict);
                end
            end
        end
    end

    initial begin : stimulus
        t_stim_row                    directed [$];
        rlfc_pkg::t_item              it;
        int unsigned                  live;
        int unsigned                  burst;
        int                           random_items;
        int                           episode;
        logic [rlfc_pkg::TOTAL_W-1:0] total;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: typed verdicts only where they are evident.
        directed.push_back(verdict_row(48'd0, rlfc_pkg::VERDICT_UNKNOWN));
        directed.push_back(cmd_row(rlfc_pkg::CMD_NOP, '1, '1, '1, '1));
        directed.push_back(cmd_row(rlfc_pkg::CMD_WRITE, 10'd0, 32'd3, 32'd0, '0));
        directed.push_back(cmd_row(rlfc_pkg::CMD_WRITE, 10'd1, 32'hFFFF_FFFF,
                                   32'h8000_0000, '1));
        directed.push_back(cmd_row(rlfc_pkg::CMD_WRITE, 10'd2, 32'd0, 32'h7FFF_FFFF, '0));
        directed.push_back(cmd_row(rlfc_pkg::CMD_WRITE, 10'd3, 32'd2, 32'hFFFF_FFFB, '0));
        directed.push_back(cmd_row(rlfc_pkg::CMD_WRITE, 10'h3FF, 32'd1, 32'd0, '0));
        directed.push_back(total_row(11'd4));
        directed.push_back(verdict_row(48'd0, rlfc_pkg::VERDICT_IN_ORDER));
        directed.push_back(cmd_row(rlfc_pkg::CMD_QUERY, '0, '0, '0, 48'd2));
        directed.push_back(cmd_row(rlfc_pkg::CMD_QUERY, '0, '0, '0, 48'd5));
        // Forward walk runs off the end and keeps its partial progress.
        directed.push_back(verdict_row(48'hFFFF_FFFF_FFFF, rlfc_pkg::VERDICT_UNKNOWN));
        // Backward walk crosses the zero-count entry.
        directed.push_back(cmd_row(rlfc_pkg::CMD_QUERY, '0, '0, '0, 48'd0));
        directed.push_back(cmd_row(rlfc_pkg::CMD_RESTART, '0, '0, '0, '0));
        directed.push_back(cmd_row(rlfc_pkg::CMD_QUERY, '0, '0, '0, 48'd3));
        directed.push_back(total_row(11'd0));
        directed.push_back(verdict_row(48'd7, rlfc_pkg::VERDICT_UNKNOWN));
        directed.push_back(total_row(11'd1));
        directed.push_back(verdict_row(48'd3, rlfc_pkg::VERDICT_UNKNOWN));
        directed.push_back(cmd_row(rlfc_pkg::CMD_RESTART, '1, '1, '1, '1));
        directed.push_back(verdict_row(48'd1, rlfc_pkg::VERDICT_IN_ORDER));
        directed.push_back(verdict_row(48'd3, rlfc_pkg::VERDICT_UNKNOWN));
        directed.push_back(cmd_row(rlfc_pkg::CMD_QUERY, '0, '0, '0, 48'd0));

        foreach (directed[i]) begin
            if (directed[i].sets_total) begin
                wait_until_idle();
                write_total(directed[i].total);
            end else begin
                send_item(directed[i].item, directed[i].has_verdict, directed[i].verdict);
            end
        end

        // Random episodes: fill the first entries, set entry_total, then a burst.
        random_items = 0;
        episode      = 0;
        while (random_items < RANDOM_ITEMS) begin
            case (episode)
                2:       total = 11'd1024;
                5:       total = 11'd2047;
                8:       total = 11'd0;
                default: total = ($urandom_range(4) == 0) ?
                                 rlfc_pkg::TOTAL_W'($urandom_range(9, 40)) :
                                 rlfc_pkg::TOTAL_W'($urandom_range(1, 8));
            endcase
            live = (total > rlfc_pkg::TABLE_DEPTH) ? rlfc_pkg::TABLE_DEPTH : total;
            for (int s = 0; s < live && s < FILL_CAP; s++) begin
                if (!slot_written[s]) begin
                    it.cmd          = rlfc_pkg::CMD_WRITE;
                    it.entry_index  = rlfc_pkg::INDEX_W'(s);
                    it.entry_count  = ($urandom_range(4) == 0) ? $urandom : $urandom_range(6);
                    it.entry_offset = $urandom;
                    it.target_frame = rlfc_pkg::FRAME_W'({$urandom, $urandom});
                    send_item(it, 1'b0, rlfc_pkg::VERDICT_IN_ORDER);
                    random_items++;
                end
            end
            wait_until_idle();
            write_total(total);

            burst = (live > 64) ? 10 : 30;
            repeat (burst) begin
                if (random_items < RANDOM_ITEMS / 3) begin
                    tx_idle_pct = 37;
                    rx_idle_pct = 54;
                end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                    tx_idle_pct = 54;
                    rx_idle_pct = 37;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                send_item(random_item(live), 1'b0, rlfc_pkg::VERDICT_IN_ORDER);
                random_items++;
            end
            episode++;
        end

        wait_until_idle();
        if (error_total == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog for a hung handshake or a runaway walk.
    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rlfc_pkg.sv
rtl/rlfc_front.sv
rtl/rlfc_back.sv
rtl/rlfc_outq.sv
rtl/run_length_frame_class_cursor.sv
tb/tb_run_length_frame_class_cursor.sv
